// ===== hdl/lsfs_pkg.sv =====
// Types and constants shared by the serial LCD frame sequencer.
// No dependencies; used by every module of the block.
`default_nettype none

package lsfs_pkg;

  // Request codes
  localparam logic [2:0] OP_BITMAP = 3'd0;
  localparam logic [2:0] OP_CMD    = 3'd1;
  localparam logic [2:0] OP_DATA   = 3'd2;
  localparam logic [2:0] OP_INIT   = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  // Sync bytes and nibble masks
  localparam logic [7:0] SYNC_CMD  = 8'hF8;
  localparam logic [7:0] SYNC_DATA = 8'hFA;
  localparam logic [7:0] HI_MASK   = 8'hF0;
  localparam logic [7:0] LO_MASK   = 8'h0F;

  // Display commands
  localparam logic [7:0] CMD_EXT_MODE  = 8'h34;
  localparam logic [7:0] CMD_BASIC     = 8'h30;
  localparam logic [7:0] CMD_GFX_ON    = 8'h36;
  localparam logic [7:0] CMD_ADDR_BASE = 8'h80;
  localparam logic [7:0] CMD_X_LOWER   = 8'h88;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
  localparam logic [7:0] CMD_CLR       = 8'h01;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;

  localparam int unsigned FRAME_MAX = 5;   // frames one item can cause
  localparam logic [5:0] ROW_LAST = 6'd63;
  localparam logic [3:0] COL_LAST = 4'd15;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_last;
  } out_item_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] payload;
  } frame_t;

  typedef struct packed {
    frame_t [FRAME_MAX-1:0] frames;
    logic   [2:0]           count;   // 0 means no output
  } plan_t;

endpackage

`default_nettype wire

// ===== hdl/lcd_serial_frame_sequencer.sv =====
// Serial LCD frame sequencer: expands display requests into the serial byte
// stream. Depends on lsfs_pkg and lsfs_frame_decode.
//
// Input channel in_valid/in_ready/in_data carries one request per item
// (opcode, value). Output channel out_valid/out_ready/out_data carries one
// byte per item, with is_last set on the final byte of each request.
// Each command or data byte goes out as three bytes: sync, high nibble,
// low nibble shifted up. A request is decoded at acceptance into a frame
// list held in a plan register; the plan is walked one byte per cycle into
// the output register while the output side is free.
// The first byte passes through the plan register and then the output
// register. Throughput: one output byte per cycle while the output side is
// free, so a request sends 3 bytes per frame (3 to 15 bytes); a plain bitmap
// byte sends 3, a row start 15, about 4 averaged over a full screen. The next
// request is taken in the cycle the last byte moves to the output register.
// Undefined opcodes are accepted and produce nothing.
// Reset clears the row and column counters and drops any pending bytes.
// When the receiver stalls, the output register holds its byte and the plan
// waits; in_ready drops once the plan is busy.
`default_nettype none

module lcd_serial_frame_sequencer (
  input  wire  logic                clk,
  input  wire  logic                rst,
  input  wire  logic                in_valid,
  output logic                      in_ready,
  input  wire  lsfs_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire  logic                out_ready,
  output lsfs_pkg::out_item_t       out_data
);

  logic [5:0]       row_index;
  logic [3:0]       column_index;
  logic [5:0]       row_index_next;
  logic [3:0]       column_index_next;
  lsfs_pkg::plan_t  dec_plan;

  lsfs_pkg::plan_t  plan;
  logic             plan_valid;
  logic [2:0]       frame_idx;
  logic [1:0]       phase;

  lsfs_pkg::frame_t cur_frame;
  logic [7:0]       cur_byte;
  logic             plan_last;
  logic             out_free;
  logic             advance;
  logic             accept;
  logic             load_plan;

  lsfs_frame_decode u_decode (
    .item              (in_data),
    .row_index         (row_index),
    .column_index      (column_index),
    .plan              (dec_plan),
    .row_index_next    (row_index_next),
    .column_index_next (column_index_next)
  );

  always_comb begin
    cur_frame = plan.frames[frame_idx];
    case (phase)
      2'd0:    cur_byte = cur_frame.is_data ? lsfs_pkg::SYNC_DATA : lsfs_pkg::SYNC_CMD;
      2'd1:    cur_byte = cur_frame.payload & lsfs_pkg::HI_MASK;
      default: cur_byte = {cur_frame.payload[3:0] & lsfs_pkg::LO_MASK[3:0], 4'd0};
    endcase
    plan_last = (frame_idx == plan.count - 3'd1) && (phase == 2'd2);
    out_free  = !out_valid || out_ready;
    advance   = plan_valid && out_free;
    in_ready  = !plan_valid || (advance && plan_last);
    accept    = in_valid && in_ready;
    load_plan = accept && (dec_plan.count != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_index    <= 6'd0;
      column_index <= 4'd0;
      plan_valid   <= 1'b0;
      out_valid    <= 1'b0;
      frame_idx    <= 3'd0;
      phase        <= 2'd0;
    end else begin
      if (advance) begin
        out_valid         <= 1'b1;
        out_data.out_byte <= cur_byte;
        out_data.is_last  <= plan_last;
        if (!plan_last) begin
          if (phase == 2'd2) begin
            phase     <= 2'd0;
            frame_idx <= frame_idx + 3'd1;
          end else begin
            phase <= phase + 2'd1;
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      // a new plan loads when no plan is held or while the old one hands off its last byte
      if (load_plan) begin
        plan       <= dec_plan;
        plan_valid <= 1'b1;
        frame_idx  <= 3'd0;
        phase      <= 2'd0;
      end else if (advance && plan_last) begin
        plan_valid <= 1'b0;
      end

      if (accept) begin
        row_index    <= row_index_next;
        column_index <= column_index_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lsfs_frame_decode.sv =====
// Turns one request plus the bitmap position into a list of frames and the
// next bitmap position. Purely combinational. Depends on lsfs_pkg.
`default_nettype none

module lsfs_frame_decode (
  input  wire  lsfs_pkg::in_item_t item,
  input  wire  logic [5:0]         row_index,
  input  wire  logic [3:0]         column_index,
  output lsfs_pkg::plan_t          plan,
  output logic [5:0]               row_index_next,
  output logic [3:0]               column_index_next
);

  function automatic lsfs_pkg::frame_t cmd(input logic [7:0] b);
    lsfs_pkg::frame_t f;
    f.is_data = 1'b0;
    f.payload = b;
    return f;
  endfunction

  logic [7:0]        y_cmd;
  logic [7:0]        x_cmd;
  lsfs_pkg::frame_t  data_frame;
  logic              wrap;

  always_comb begin
    y_cmd = lsfs_pkg::CMD_ADDR_BASE | {3'd0, row_index[4:0]};
    x_cmd = row_index[5] ? lsfs_pkg::CMD_X_LOWER : lsfs_pkg::CMD_ADDR_BASE;
    data_frame.is_data = 1'b1;
    data_frame.payload = item.value;
    wrap = (column_index == lsfs_pkg::COL_LAST) && (row_index == lsfs_pkg::ROW_LAST);

    plan.frames       = '0;
    plan.count        = 3'd0;
    row_index_next    = row_index;
    column_index_next = column_index;

    case (item.opcode)
      lsfs_pkg::OP_BITMAP: begin
        if (column_index == 4'd0) begin
          // row header, then the byte
          plan.frames[0] = cmd(lsfs_pkg::CMD_EXT_MODE);
          plan.frames[1] = cmd(y_cmd);
          plan.frames[2] = cmd(x_cmd);
          plan.frames[3] = cmd(lsfs_pkg::CMD_BASIC);
          plan.frames[4] = data_frame;
          plan.count     = 3'd5;
        end else if (wrap) begin
          plan.frames[0] = data_frame;
          plan.frames[1] = cmd(lsfs_pkg::CMD_EXT_MODE);
          plan.frames[2] = cmd(lsfs_pkg::CMD_GFX_ON);
          plan.count     = 3'd3;
        end else begin
          plan.frames[0] = data_frame;
          plan.count     = 3'd1;
        end
        column_index_next = column_index + 4'd1;
        if (column_index == lsfs_pkg::COL_LAST) begin
          row_index_next = row_index + 6'd1;
        end
      end
      lsfs_pkg::OP_CMD: begin
        plan.frames[0] = cmd(item.value);
        plan.count     = 3'd1;
      end
      lsfs_pkg::OP_DATA: begin
        plan.frames[0] = data_frame;
        plan.count     = 3'd1;
      end
      lsfs_pkg::OP_INIT: begin
        plan.frames[0] = cmd(lsfs_pkg::CMD_BASIC);
        plan.frames[1] = cmd(lsfs_pkg::CMD_DISP_ON);
        plan.frames[2] = cmd(lsfs_pkg::CMD_CLR);
        plan.frames[3] = cmd(lsfs_pkg::CMD_ENTRY);
        plan.count     = 3'd4;
      end
      lsfs_pkg::OP_CLEAR: begin
        plan.frames[0] = cmd(lsfs_pkg::CMD_BASIC);
        plan.frames[1] = cmd(lsfs_pkg::CMD_CLR);
        plan.count     = 3'd2;
      end
      default: begin
        plan.count = 3'd0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/lsfs_checker.sv =====
// Port-level checks for the serial LCD frame sequencer, bound to the top.
// Depends on lsfs_pkg and lcd_serial_frame_sequencer.
`default_nettype none

module lsfs_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire lsfs_pkg::in_item_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire lsfs_pkg::out_item_t out_data
);

  // stalled output holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // an accepted request with a defined opcode is followed by out_valid after the plan and output registers
  a_first_byte: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.opcode == lsfs_pkg::OP_BITMAP ||
      in_data.opcode == lsfs_pkg::OP_CMD || in_data.opcode == lsfs_pkg::OP_DATA ||
      in_data.opcode == lsfs_pkg::OP_INIT || in_data.opcode == lsfs_pkg::OP_CLEAR)
    |=> ##1 out_valid)
    else $error("no output after a valid request");

  // bytes of one item stream without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.is_last |=> out_valid)
    else $error("gap inside an item's byte stream");

endmodule

bind lcd_serial_frame_sequencer lsfs_checker u_lsfs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
